// File: hw/rtl/apf_pkg.sv
// Shared types, constants and helper functions of the request frame encoder.
package apf_pkg;

	localparam int Q_DEPTH = 8;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_DATA  = 1'b1;

	localparam logic [7:0] ENQ_BYTE = 8'h05;
	localparam logic [7:0] CR_BYTE  = 8'h0D;
	localparam logic [7:0] LF_BYTE  = 8'h0A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_W     = 8'h57;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_M     = 8'h4D;

	localparam logic [13:0] ADDR_MOD = 14'd10000;

	// header byte positions
	localparam logic [3:0] HP_ENQ  = 4'd0;
	localparam logic [3:0] HP_ST0  = 4'd1;
	localparam logic [3:0] HP_ST1  = 4'd2;
	localparam logic [3:0] HP_PC0  = 4'd3;
	localparam logic [3:0] HP_PC1  = 4'd4;
	localparam logic [3:0] HP_CMD0 = 4'd5;
	localparam logic [3:0] HP_CMD1 = 4'd6;
	localparam logic [3:0] HP_WAIT = 4'd7;
	localparam logic [3:0] HP_DEV  = 4'd8;
	localparam logic [3:0] HP_A3   = 4'd9;
	localparam logic [3:0] HP_A2   = 4'd10;
	localparam logic [3:0] HP_A1   = 4'd11;
	localparam logic [3:0] HP_A0   = 4'd12;
	localparam logic [3:0] HP_CNT1 = 4'd13;
	localparam logic [3:0] HP_LAST = 4'd14;

	// trailer byte positions
	localparam logic [3:0] TP_SUM1 = 4'd0;
	localparam logic [3:0] TP_SUM0 = 4'd1;
	localparam logic [3:0] TP_CR   = 4'd2;
	localparam logic [3:0] TP_LF   = 4'd3;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_HDR,
		BK_TRL
	} apf_bk_state_t;

	typedef struct packed {
		logic       is_start;
		logic       wr;
		logic       word;
		logic       close;
		logic [3:0] d3;
		logic [3:0] d2;
		logic [3:0] d1;
		logic [3:0] d0;
		logic [7:0] cnt;
		logic [7:0] data;
	} apf_cmd_t;

	typedef struct packed {
		logic [3:0]  digit;
		logic [13:0] rest;
	} apf_dsplit_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib <= 4'd9) begin
			c = CH_0 + 8'(nib);
		end else begin
			c = 8'h37 + 8'(nib);
		end
		return c;
	endfunction

	// one decimal digit by parallel threshold compares
	function automatic apf_dsplit_t dec_split(input logic [13:0] v, input int unit);
		apf_dsplit_t r;
		r.digit = 4'd0;
		r.rest  = v;
		for (int k = 1; k <= 9; k++) begin
			if (v >= 14'(k * unit)) begin
				r.digit = 4'(k);
				r.rest  = v - 14'(k * unit);
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input apf_cmd_t c);
		logic [7:0] b;
		case (idx)
			HP_ENQ:          b = ENQ_BYTE;
			HP_ST0, HP_ST1:  b = CH_0;
			HP_PC0, HP_PC1:  b = CH_F;
			HP_CMD0:         b = c.word ? CH_W : CH_B;
			HP_CMD1:         b = c.wr ? CH_W : CH_R;
			HP_WAIT:         b = CH_0;
			HP_DEV:          b = c.word ? CH_D : CH_M;
			HP_A3:           b = CH_0 + 8'(c.d3);
			HP_A2:           b = CH_0 + 8'(c.d2);
			HP_A1:           b = CH_0 + 8'(c.d1);
			HP_A0:           b = CH_0 + 8'(c.d0);
			HP_CNT1:         b = hex_char(c.cnt[7:4]);
			HP_LAST:         b = hex_char(c.cnt[3:0]);
			default:         b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// File: hw/rtl/apf_front.sv
// Front end: accepts words, tracks the open write frame, converts the address to decimal.
module apf_front
	import apf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              action,
	input  logic              is_write,
	input  logic              word_device,
	input  logic [13:0]       base_addr,
	input  logic [7:0]        word_count,
	input  logic [7:0]        data_char,
	input  logic [Q_AW:0]     q_count,
	output logic              q_push,
	output apf_cmd_t          q_wdata
);

	typedef struct packed {
		logic        is_start;
		logic        wr;
		logic        word;
		logic        close;
		logic [13:0] addr;
		logic [7:0]  cnt;
		logic [7:0]  data;
	} apf_s1_t;

	typedef struct packed {
		logic        is_start;
		logic        wr;
		logic        word;
		logic        close;
		logic [3:0]  d3;
		logic [9:0]  rest;
		logic [7:0]  cnt;
		logic [7:0]  data;
	} apf_s2_t;

	typedef struct packed {
		logic        is_start;
		logic        wr;
		logic        word;
		logic        close;
		logic [3:0]  d3;
		logic [3:0]  d2;
		logic [6:0]  rest;
		logic [7:0]  cnt;
		logic [7:0]  data;
	} apf_s3_t;

	logic [9:0]  chars_left_q, chars_left_d, cl_start;
	logic        acc, keep;
	logic [Q_AW+1:0] used;
	apf_s1_t     in_c, pl_s1;
	apf_s2_t     pl_s2;
	apf_s3_t     pl_s3;
	logic        valid_s1, valid_s2, valid_s3;
	apf_dsplit_t sp3, sp2, sp1;

	// credit check: every word in flight has a reserved queue slot
	assign used = (Q_AW+2)'(q_count) + (Q_AW+2)'(valid_s1) + (Q_AW+2)'(valid_s2)
		+ (Q_AW+2)'(valid_s3);
	assign full = used >= (Q_AW+2)'(Q_DEPTH);
	assign acc  = push && !full;

	assign cl_start = is_write ? (word_device ? {word_count, 2'b00} : {2'b00, word_count})
		: 10'd0;

	always_comb begin
		in_c.wr    = is_write;
		in_c.word  = word_device;
		in_c.addr  = (base_addr >= ADDR_MOD) ? (base_addr - ADDR_MOD) : base_addr;
		in_c.cnt   = word_count;
		in_c.data  = data_char;
		if (action == ACT_START) begin
			keep          = 1'b1;
			in_c.is_start = 1'b1;
			in_c.close    = (cl_start == 10'd0);
			chars_left_d  = cl_start;
		end else if (chars_left_q != 10'd0) begin
			keep          = 1'b1;
			in_c.is_start = 1'b0;
			in_c.close    = (chars_left_q == 10'd1);
			chars_left_d  = chars_left_q - 10'd1;
		end else begin
			// data outside an open write frame is dropped here
			keep          = 1'b0;
			in_c.is_start = 1'b0;
			in_c.close    = 1'b0;
			chars_left_d  = 10'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_left_q <= 10'd0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
		end else begin
			if (acc) begin
				chars_left_q <= chars_left_d;
			end
			valid_s1 <= acc && keep;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign sp3 = dec_split(pl_s1.addr, 1000);
	assign sp2 = dec_split({4'd0, pl_s2.rest}, 100);
	assign sp1 = dec_split({7'd0, pl_s3.rest}, 10);

	always_ff @(posedge clk) begin
		pl_s1 <= in_c;

		pl_s2.is_start <= pl_s1.is_start;
		pl_s2.wr       <= pl_s1.wr;
		pl_s2.word     <= pl_s1.word;
		pl_s2.close    <= pl_s1.close;
		pl_s2.d3       <= sp3.digit;
		pl_s2.rest     <= sp3.rest[9:0];
		pl_s2.cnt      <= pl_s1.cnt;
		pl_s2.data     <= pl_s1.data;

		pl_s3.is_start <= pl_s2.is_start;
		pl_s3.wr       <= pl_s2.wr;
		pl_s3.word     <= pl_s2.word;
		pl_s3.close    <= pl_s2.close;
		pl_s3.d3       <= pl_s2.d3;
		pl_s3.d2       <= sp2.digit;
		pl_s3.rest     <= sp2.rest[6:0];
		pl_s3.cnt      <= pl_s2.cnt;
		pl_s3.data     <= pl_s2.data;
	end

	assign q_push = valid_s3;

	always_comb begin
		q_wdata.is_start = pl_s3.is_start;
		q_wdata.wr       = pl_s3.wr;
		q_wdata.word     = pl_s3.word;
		q_wdata.close    = pl_s3.close;
		q_wdata.d3       = pl_s3.d3;
		q_wdata.d2       = pl_s3.d2;
		q_wdata.d1       = sp1.digit;
		q_wdata.d0       = sp1.rest[3:0];
		q_wdata.cnt      = pl_s3.cnt;
		q_wdata.data     = pl_s3.data;
	end

endmodule

// File: hw/rtl/apf_queue.sv
// Command queue between the front end and the byte sequencer.
module apf_queue
	import apf_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  apf_cmd_t      wdata,
	input  logic          rd_en,
	output apf_cmd_t      rdata,
	output logic          q_empty,
	output logic [Q_AW:0] count
);

	apf_cmd_t          mem_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [Q_AW:0]     count_q;

	assign rdata   = mem_q[rd_ptr_q];
	assign q_empty = (count_q == '0);
	assign count   = count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && !rd_en |-> count_q < (Q_AW+1)'(Q_DEPTH))
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> count_q != '0)
		else $error("queue underflow");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers out of step");
`endif

endmodule

// File: hw/rtl/apf_back.sv
// Byte sequencer: expands commands into header, data and trailer bytes with checksum.
module apf_back
	import apf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  apf_cmd_t    q_head,
	output logic        q_pop,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        frame_end
);

	apf_bk_state_t st_q, st_d;
	logic [3:0]    idx_q, idx_d;
	logic [7:0]    sum_q, sum_d;
	apf_cmd_t      cmd_q, cmd_d;
	logic          ovalid_q;
	logic [7:0]    obyte_q;
	logic          oend_q;
	logic          adv, ld, le;
	logic [7:0]    lb, hb;

	assign adv = !ovalid_q || pop;
	assign hb  = hdr_byte(idx_q, cmd_q);

	always_comb begin
		st_d  = st_q;
		idx_d = idx_q;
		sum_d = sum_q;
		cmd_d = cmd_q;
		ld    = 1'b0;
		lb    = 8'h00;
		le    = 1'b0;
		q_pop = 1'b0;
		if (adv) begin
			case (st_q)
				BK_IDLE: begin
					if (!q_empty) begin
						q_pop = 1'b1;
						ld    = 1'b1;
						if (q_head.is_start) begin
							lb    = ENQ_BYTE;
							sum_d = 8'h00;
							cmd_d = q_head;
							idx_d = HP_ST0;
							st_d  = BK_HDR;
						end else begin
							lb    = q_head.data;
							sum_d = sum_q + q_head.data;
							if (q_head.close) begin
								idx_d = TP_SUM1;
								st_d  = BK_TRL;
							end
						end
					end
				end
				BK_HDR: begin
					ld    = 1'b1;
					lb    = hb;
					sum_d = sum_q + hb;
					if (idx_q == HP_LAST) begin
						idx_d = TP_SUM1;
						st_d  = cmd_q.close ? BK_TRL : BK_IDLE;
					end else begin
						idx_d = idx_q + 4'd1;
					end
				end
				BK_TRL: begin
					ld    = 1'b1;
					idx_d = idx_q + 4'd1;
					case (idx_q)
						TP_SUM1: lb = hex_char(sum_q[7:4]);
						TP_SUM0: lb = hex_char(sum_q[3:0]);
						TP_CR:   lb = CR_BYTE;
						default: begin
							lb    = LF_BYTE;
							le    = 1'b1;
							st_d  = BK_IDLE;
						end
					endcase
				end
				default: st_d = BK_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= BK_IDLE;
			idx_q    <= 4'd0;
			sum_q    <= 8'h00;
			ovalid_q <= 1'b0;
		end else begin
			st_q  <= st_d;
			idx_q <= idx_d;
			sum_q <= sum_d;
			if (ld) begin
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
		if (ld) begin
			obyte_q <= lb;
			oend_q  <= le;
		end
	end

	assign empty     = !ovalid_q;
	assign out_byte  = obyte_q;
	assign frame_end = oend_q;

`ifndef SYNTHESIS
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> st_q == BK_IDLE)
		else $error("command taken while sequencer busy");
	a_hdr_idx: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == BK_HDR |-> (idx_q >= HP_ST0 && idx_q <= HP_LAST))
		else $error("header index out of range");
	a_trl_idx: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == BK_TRL |-> idx_q <= TP_LF)
		else $error("trailer index out of range");
`endif

endmodule

// File: hw/rtl/ascii_plc_request_frame_encoder_top.sv
// Top level of the ASCII request frame encoder.
// A start word produces a frame header (ENQ, "00FF", command, "0", device letter, four
// address digits, two hex count digits); read frames and zero-count writes then close at
// once with two hex checksum digits, CR and LF (19 bytes). Each data word of an open write
// frame yields one byte, and the last one is followed by the trailer. Data words outside
// an open frame are dropped; a start word abandons an open frame. One word is accepted per
// cycle while the 8-entry command queue has room (credits cover the 3-stage front pipeline);
// bytes leave through a single output register at one per cycle while the receiver pops, so
// a start word yields 15 or 19 bytes, a data word one, or five when it closes the frame. With the
// output idle, the first byte of a word passes the front stages, the queue and the output register.
module ascii_plc_request_frame_encoder_top
	import apf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic        is_write,
	input  logic        word_device,
	input  logic [13:0] base_addr,
	input  logic [7:0]  word_count,
	input  logic [7:0]  data_char,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        frame_end
);

	logic          q_push, q_pop, q_empty;
	apf_cmd_t      q_wdata, q_head;
	logic [Q_AW:0] q_count;

	apf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.action      (action),
		.is_write    (is_write),
		.word_device (word_device),
		.base_addr   (base_addr),
		.word_count  (word_count),
		.data_char   (data_char),
		.q_count     (q_count),
		.q_push      (q_push),
		.q_wdata     (q_wdata)
	);

	apf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wdata   (q_wdata),
		.rd_en   (q_pop),
		.rdata   (q_head),
		.q_empty (q_empty),
		.count   (q_count)
	);

	apf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.frame_end (frame_end)
	);

endmodule

// File: dv/ascii_plc_request_frame_encoder_top_test.sv
// Self-checking testbench of the ASCII request frame encoder: directed table plus random frames.
module ascii_plc_request_frame_encoder_top_test
	import apf_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RAND_ITEMS  = 200;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 12;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 100;

	typedef struct packed {
		logic        act;
		logic        wr;
		logic        word;
		logic [13:0] addr;
		logic [7:0]  cnt;
		logic [7:0]  data;
	} req_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_byte_t;

	// how a directed row gets its expected bytes
	typedef enum logic [1:0] {
		EXP_PRED,
		EXP_NONE,
		EXP_FRAME
	} exp_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        action = ACT_START;
	logic        is_write = 1'b0;
	logic        word_device = 1'b0;
	logic [13:0] base_addr = '0;
	logic [7:0]  word_count = '0;
	logic [7:0]  data_char = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [7:0]  out_byte;
	logic        frame_end;

	ascii_plc_request_frame_encoder_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.action      (action),
		.is_write    (is_write),
		.word_device (word_device),
		.base_addr   (base_addr),
		.word_count  (word_count),
		.data_char   (data_char),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.frame_end   (frame_end)
	);

	always #10 clk = ~clk;

	// predictor state
	logic       wr_open = 1'b0;
	logic [9:0] data_left = '0;
	logic [7:0] ck_sum = '0;

	frame_byte_t frame_bytes_due[$];
	frame_byte_t word_bytes[$];
	frame_byte_t got_due;

	req_t      dir_req[$];
	exp_kind_t dir_kind[$];
	string     dir_want[$];

	int errors = 0;
	int items_done = 0;
	int burst_left = 0;
	int hold_reqs = 0;
	int hold_served = 0;
	int hold_left = 0;
	int pat_left = 0;
	int cycle_cnt = 0;
	logic [15:0] pop_pat = '1;

	function automatic logic [7:0] nib_ascii(input logic [3:0] n);
		return (n < 4'd10) ? CH_0 + 8'(n) : 8'(n - 4'd10) + 8'h41;
	endfunction

	function void emit_byte(input logic [7:0] b, input bit summed, input logic last);
		frame_byte_t fb;
		fb.data = b;
		fb.last = last;
		word_bytes.push_back(fb);
		if (summed) ck_sum = ck_sum + b;
	endfunction

	function void close_frame();
		emit_byte(nib_ascii(ck_sum[7:4]), 1'b0, 1'b0);
		emit_byte(nib_ascii(ck_sum[3:0]), 1'b0, 1'b0);
		emit_byte(CR_BYTE, 1'b0, 1'b0);
		emit_byte(LF_BYTE, 1'b0, 1'b1);
		wr_open = 1'b0;
		data_left = '0;
	endfunction

	// bytes caused by one accepted word, left in word_bytes
	function void encode_word(input req_t r);
		int a;
		word_bytes.delete();
		if (r.act == ACT_START) begin
			a = int'(r.addr % ADDR_MOD);
			ck_sum = '0;
			wr_open = 1'b0;
			data_left = '0;
			emit_byte(ENQ_BYTE, 1'b0, 1'b0);
			emit_byte(CH_0, 1'b1, 1'b0);
			emit_byte(CH_0, 1'b1, 1'b0);
			emit_byte(CH_F, 1'b1, 1'b0);
			emit_byte(CH_F, 1'b1, 1'b0);
			emit_byte(r.word ? CH_W : CH_B, 1'b1, 1'b0);
			emit_byte(r.wr ? CH_W : CH_R, 1'b1, 1'b0);
			emit_byte(CH_0, 1'b1, 1'b0);
			emit_byte(r.word ? CH_D : CH_M, 1'b1, 1'b0);
			emit_byte(CH_0 + 8'((a / 1000) % 10), 1'b1, 1'b0);
			emit_byte(CH_0 + 8'((a / 100) % 10), 1'b1, 1'b0);
			emit_byte(CH_0 + 8'((a / 10) % 10), 1'b1, 1'b0);
			emit_byte(CH_0 + 8'(a % 10), 1'b1, 1'b0);
			emit_byte(nib_ascii(r.cnt[7:4]), 1'b1, 1'b0);
			emit_byte(nib_ascii(r.cnt[3:0]), 1'b1, 1'b0);
			if (r.wr) data_left = r.word ? {r.cnt, 2'b00} : {2'b00, r.cnt};
			if (data_left != '0) begin
				wr_open = 1'b1;
			end else begin
				close_frame();
			end
		end else if (!wr_open || data_left == '0) begin
			wr_open = 1'b0;
			data_left = '0;
		end else begin
			emit_byte(r.data, 1'b1, 1'b0);
			data_left = data_left - 10'd1;
			if (data_left == '0) close_frame();
		end
	endfunction

	function automatic req_t rand_req(input logic act);
		req_t r;
		r.act  = act;
		r.wr   = 1'($urandom_range(0, 1));
		r.word = 1'($urandom_range(0, 1));
		r.addr = 14'($urandom_range(0, 16383));
		r.cnt  = 8'($urandom_range(0, 255));
		r.data = 8'($urandom_range(0, 255));
		return r;
	endfunction

	function void row(input logic act, input logic wr, input logic word, input logic [13:0] addr,
			input logic [7:0] cnt, input logic [7:0] data, input exp_kind_t kind, input string want);
		req_t r;
		r.act  = act;
		r.wr   = wr;
		r.word = word;
		r.addr = addr;
		r.cnt  = cnt;
		r.data = data;
		dir_req.push_back(r);
		dir_kind.push_back(kind);
		dir_want.push_back(want);
	endfunction

	// offer one word, wait for it to be taken, then queue its expected bytes
	task automatic send_word(input req_t r, input exp_kind_t kind, input string want);
		frame_byte_t fb;
		action      <= r.act;
		is_write    <= r.wr;
		word_device <= r.word;
		base_addr   <= r.addr;
		word_count  <= r.cnt;
		data_char   <= r.data;
		push        <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		encode_word(r);
		if (r.act == ACT_START || word_bytes.size() != 0) items_done++;
		if (kind != EXP_PRED) begin
			word_bytes.delete();
			if (kind == EXP_FRAME) begin
				fb.last = 1'b0;
				fb.data = ENQ_BYTE;
				word_bytes.push_back(fb);
				for (int k = 0; k < want.len(); k++) begin
					fb.data = want[k];
					word_bytes.push_back(fb);
				end
				fb.data = CR_BYTE;
				word_bytes.push_back(fb);
				fb.data = LF_BYTE;
				fb.last = 1'b1;
				word_bytes.push_back(fb);
			end
		end
		foreach (word_bytes[k]) frame_bytes_due.push_back(word_bytes[k]);
	endtask

	task automatic send_data();
		send_word(rand_req(ACT_DATA), EXP_PRED, "");
	endtask

	// sender bursts with random gaps, now and then a long gap-free stretch
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 15);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		while (frame_bytes_due.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// receiver: stall pattern of its own, plus long hold-offs on request
	always @(posedge clk) begin
		if (hold_served != hold_reqs) begin
			hold_served = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			if (pat_left == 0) begin
				pat_left = $urandom_range(8, 64);
				case ($urandom_range(0, 3))
					0: pop_pat = '1;
					1: pop_pat = 16'($urandom);
					2: pop_pat = 16'($urandom) | 16'($urandom);
					default: pop_pat = 16'($urandom) & 16'($urandom);
				endcase
				if (pop_pat == '0) pop_pat = 16'h0001;
			end
			pat_left--;
			pop <= pop_pat[0];
			pop_pat = {pop_pat[0], pop_pat[15:1]};
		end
	end

	always @(posedge clk) begin
		if (arst_n && !empty && pop) begin
			if (frame_bytes_due.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: expected no word, actual out_byte %02h frame_end %0b",
						$time, out_byte, frame_end);
			end else begin
				got_due = frame_bytes_due.pop_front();
				if (out_byte !== got_due.data) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: out_byte expected %02h actual %02h",
							$time, got_due.data, out_byte);
				end
				if (frame_end !== got_due.last) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: frame_end expected %0b actual %0b",
							$time, got_due.last, frame_end);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d bytes still due", $time, frame_bytes_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		req_t r;
		int   n;
		int   pick;
		int   target;
		bit   paused;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		row(ACT_DATA,  1'b1, 1'b1, 14'h3FFF, 8'hFF, 8'h55, EXP_NONE, "");
		row(ACT_START, 1'b0, 1'b0, 14'd0, 8'h00, 8'hFF, EXP_FRAME, "00FFBR0M0000001D");
		row(ACT_START, 1'b0, 1'b1, 14'd9999, 8'hFF, 8'h00, EXP_FRAME, "00FFWR0D9999FF79");
		row(ACT_START, 1'b0, 1'b1, 14'h3FFF, 8'hA5, 8'hAA, EXP_PRED, "");
		row(ACT_START, 1'b0, 1'b0, 14'd10000, 8'h5A, 8'h00, EXP_PRED, "");
		// zero-count writes close at once
		row(ACT_START, 1'b1, 1'b1, 14'd1234, 8'h00, 8'h00, EXP_PRED, "");
		row(ACT_START, 1'b1, 1'b0, 14'd5678, 8'h00, 8'h00, EXP_PRED, "");
		row(ACT_START, 1'b1, 1'b0, 14'd42, 8'h03, 8'h00, EXP_PRED, "");
		row(ACT_DATA,  1'b0, 1'b0, 14'h3FFF, 8'hFF, 8'h00, EXP_PRED, "");
		row(ACT_DATA,  1'b1, 1'b1, 14'h0000, 8'h00, 8'hFF, EXP_PRED, "");
		row(ACT_DATA,  1'b0, 1'b1, 14'h1555, 8'h33, 8'h5A, EXP_PRED, "");
		row(ACT_DATA,  1'b1, 1'b0, 14'h2AAA, 8'hCC, 8'hA5, EXP_NONE, "");
		row(ACT_START, 1'b1, 1'b1, 14'd8765, 8'h01, 8'h00, EXP_PRED, "");
		row(ACT_DATA,  1'b0, 1'b0, 14'd0, 8'h00, LF_BYTE, EXP_PRED, "");
		row(ACT_DATA,  1'b0, 1'b0, 14'd0, 8'h00, 8'h80, EXP_PRED, "");
		row(ACT_DATA,  1'b0, 1'b0, 14'd0, 8'h00, 8'h7F, EXP_PRED, "");
		row(ACT_DATA,  1'b0, 1'b0, 14'd0, 8'h00, CR_BYTE, EXP_PRED, "");
		// start while a write frame is open abandons it
		row(ACT_START, 1'b1, 1'b0, 14'd3, 8'h05, 8'h00, EXP_PRED, "");
		row(ACT_DATA,  1'b0, 1'b0, 14'd0, 8'h00, 8'h31, EXP_PRED, "");
		row(ACT_DATA,  1'b0, 1'b0, 14'd0, 8'h00, 8'hC3, EXP_PRED, "");
		row(ACT_START, 1'b0, 1'b1, 14'd100, 8'h10, 8'h00, EXP_PRED, "");
		row(ACT_DATA,  1'b0, 1'b0, 14'd0, 8'h00, 8'h44, EXP_NONE, "");
		row(ACT_START, 1'b1, 1'b1, 14'd9000, 8'hFF, 8'h00, EXP_PRED, "");
		row(ACT_START, 1'b1, 1'b0, 14'd777, 8'hF0, 8'h00, EXP_PRED, "");
		row(ACT_START, 1'b0, 1'b0, 14'd1, 8'h0F, 8'h00, EXP_PRED, "");

		foreach (dir_req[i]) begin
			send_word(dir_req[i], dir_kind[i], dir_want[i]);
			pace();
		end
		drain();

		// receiver holds off while the random part starts, so the input backs up
		hold_reqs++;
		target = items_done + RAND_ITEMS;
		paused = 1'b0;
		while (items_done < target) begin
			if (!paused && items_done >= target - RAND_ITEMS / 2) begin
				paused = 1'b1;
				drain();
			end
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				r = rand_req(ACT_START);
				r.wr = 1'b0;
				send_word(r, EXP_PRED, "");
				pace();
			end else if (pick < 25) begin
				send_data();
				pace();
			end else if (pick < 35) begin
				// broken frame: write opened, then cut short by what follows unless the data words sent complete it
				r = rand_req(ACT_START);
				r.wr = 1'b1;
				if (r.cnt == '0) r.cnt = 8'h01;
				send_word(r, EXP_PRED, "");
				pace();
				repeat ($urandom_range(0, 3)) begin
					send_data();
					pace();
				end
			end else if (pick < 40) begin
				r = rand_req(ACT_START);
				r.wr = 1'b1;
				r.cnt = '0;
				send_word(r, EXP_PRED, "");
				pace();
			end else begin
				r = rand_req(ACT_START);
				r.wr = 1'b1;
				if (r.word)
					r.cnt = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(4, 8))
						: 8'($urandom_range(1, 3));
				else
					r.cnt = ($urandom_range(0, 14) == 0) ? 8'($urandom_range(11, 40))
						: 8'($urandom_range(1, 10));
				send_word(r, EXP_PRED, "");
				pace();
				n = r.word ? 4 * int'(r.cnt) : int'(r.cnt);
				repeat (n) begin
					send_data();
					pace();
				end
			end
		end
		drain();

		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/apf_pkg.sv
hw/rtl/apf_front.sv
hw/rtl/apf_queue.sv
hw/rtl/apf_back.sv
hw/rtl/ascii_plc_request_frame_encoder_top.sv
dv/ascii_plc_request_frame_encoder_top_test.sv
